[sv/md5_pkg.sv]
// Shared constants, types and helpers for the MD5 digest stream block.
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int BlockBytes = 64;
  localparam int LenOffset = 56;

  // datapath commands from the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,   // store input byte at fill position
    CMD_PAD,     // write one padding byte at pad position
    CMD_ROUND,   // one compression step
    CMD_FINISH,  // fold working words into chain words
    CMD_CLEAR    // restore reset values
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [5:0] addr;   // byte address or step index
    logic [7:0] wbyte;  // byte for write or pad
    logic       count;  // bump the message length on write
  } dp_ctrl_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [60:0] msg_bytes;
  } dp_stat_t;

  function automatic logic [31:0] step_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] step_rot(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;  4'd1: r = 5'd12; 4'd2: r = 5'd17; 4'd3: r = 5'd22;
      4'd4: r = 5'd5;  4'd5: r = 5'd9;  4'd6: r = 5'd14; 4'd7: r = 5'd20;
      4'd8: r = 5'd4;  4'd9: r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6; 4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] step_word(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'((i[3:0] * 4'd5) + 4'd1);
      2'd2: g = 4'((i[3:0] * 4'd3) + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

[sv/md5_datapath.sv]
// MD5 datapath: block buffer, chaining and working words, length count.
module md5_datapath import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_ctrl_t    ctrl,
  input  logic [5:0]  next_step,   // step whose word is fetched this cycle
  output dp_stat_t    stat,
  output logic [63:0] half_lo,
  output logic [63:0] half_hi
);

  // 16 words of 32 bits, byte-written
  logic [31:0] words [16];
  logic [31:0] word_q;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] wa, wb, wc, wd;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic [31:0] f, t, rot;
  logic [4:0]  s;

  always_ff @(posedge clk) begin
    if ((ctrl.cmd == CMD_WRITE) || (ctrl.cmd == CMD_PAD)) begin
      words[ctrl.addr[5:2]][ctrl.addr[1:0]*8 +: 8] <= ctrl.wbyte;
    end
    word_q <= words[step_word(next_step)];
  end

  always_comb begin
    case (ctrl.addr[5:4])
      2'd0: f = (wb & wc) | (~wb & wd);
      2'd1: f = (wb & wd) | (wc & ~wd);
      2'd2: f = wb ^ wc ^ wd;
      default: f = wc ^ (wb | ~wd);
    endcase
    t = wa + f + step_k(ctrl.addr) + word_q;
    s = step_rot(ctrl.addr);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (rst || (ctrl.cmd == CMD_CLEAR)) begin
      ca <= IV_A; cb <= IV_B; cc <= IV_C; cd <= IV_D;
      wa <= IV_A; wb <= IV_B; wc <= IV_C; wd <= IV_D;
      fill <= '0;
      msg_bytes <= '0;
    end else begin
      case (ctrl.cmd)
        CMD_WRITE: begin
          fill <= fill + 6'd1;
          if (ctrl.count) msg_bytes <= msg_bytes + 61'd1;
        end
        CMD_ROUND: begin
          wa <= wd; wd <= wc; wc <= wb;
          wb <= wb + rot;
        end
        CMD_FINISH: begin
          ca <= ca + wa; cb <= cb + wb; cc <= cc + wc; cd <= cd + wd;
          wa <= ca + wa; wb <= cb + wb; wc <= cc + wc; wd <= cd + wd;
        end
        default: ;
      endcase
    end
  end

  assign stat.fill = fill;
  assign stat.msg_bytes = msg_bytes;
  assign half_lo = {cb, ca};
  assign half_hi = {cd, cc};

endmodule

[sv/md5_control.sv]
// MD5 controller: byte intake, padding, compression sequencing, output.
module md5_control import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic [7:0]  in_byte,
  input  logic        in_has,
  input  logic        in_end,
  input  dp_stat_t    stat,
  input  logic        out_ready,
  output logic        in_rdy,
  output dp_ctrl_t    ctrl,
  output logic [5:0]  next_step,
  output logic        out_valid,
  output logic        out_half
);

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_FOLD, S_PAD, S_SEND
  } state_t;

  state_t      state;
  logic [5:0]  step;
  logic [5:0]  pad_pos;
  logic        pending_end;  // message end seen, padding still to do
  logic        len_done;     // the block now running holds the length
  logic        extra_pass;   // padding the second block: zeros and length only
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;

  assign bit_len = {stat.msg_bytes, 3'b000};
  assign in_rdy = (state == S_IDLE);

  always_comb begin
    if ((pad_pos >= 6'(LenOffset)) && (extra_pass || (stat.fill < 6'(LenOffset)))) begin
      pad_byte = bit_len[pad_pos[2:0]*8 +: 8];
    end else if ((pad_pos == stat.fill) && !extra_pass) begin
      pad_byte = PAD_BYTE;
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    ctrl = '{cmd: CMD_NONE, addr: 6'd0, wbyte: 8'h00, count: 1'b0};
    next_step = 6'd0;
    case (state)
      S_IDLE: begin
        if (in_fire && in_has) begin
          ctrl = '{cmd: CMD_WRITE, addr: stat.fill, wbyte: in_byte, count: 1'b1};
        end
      end
      S_RUN: begin
        ctrl.cmd = CMD_ROUND;
        ctrl.addr = step;
        next_step = step + 6'd1;
      end
      S_FOLD: ctrl.cmd = CMD_FINISH;
      S_PAD: begin
        ctrl.cmd = CMD_PAD;
        ctrl.addr = pad_pos;
        ctrl.wbyte = pad_byte;
      end
      S_SEND: begin
        if (out_ready && out_half) ctrl.cmd = CMD_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      pad_pos <= '0;
      pending_end <= 1'b0;
      len_done <= 1'b0;
      extra_pass <= 1'b0;
      out_valid <= 1'b0;
      out_half <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pending_end <= in_end;
            len_done <= 1'b0;
            extra_pass <= 1'b0;
            if (in_has && (stat.fill == 6'd63)) begin
              state <= S_RUN;
              step <= '0;
            end else if (in_end) begin
              state <= S_PAD;
              pad_pos <= in_has ? stat.fill + 6'd1 : stat.fill;
            end
          end
        end
        S_RUN: begin
          step <= step + 6'd1;
          if (step == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          if (len_done) begin
            state <= S_SEND;
            out_valid <= 1'b1;
            out_half <= 1'b0;
          end else if (pending_end) begin
            // next padding block is written whole, from byte zero
            state <= S_PAD;
            pad_pos <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            state <= S_RUN;
            step <= '0;
            // no room for the length when the marker lands at 56 or later
            len_done <= extra_pass || (stat.fill < 6'(LenOffset));
            extra_pass <= !extra_pass && (stat.fill >= 6'(LenOffset));
            if (stat.fill >= 6'(LenOffset)) begin
              pending_end <= 1'b1;
            end
          end
        end
        S_SEND: begin
          if (out_ready) begin
            if (out_half) begin
              state <= S_IDLE;
              out_valid <= 1'b0;
              out_half <= 1'b0;
              pending_end <= 1'b0;
            end else begin
              out_half <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/md5_digest_stream.sv]
// Top level of the streaming MD5 digest block.
// At most one message byte per input transaction; bytes are taken at once while
// the buffer fills, and the 64th byte of a block holds the input through the
// compression, run step by step on the shared round unit (the first word is
// fetched while that byte is written), and the fold into the chaining words.
// An end transaction writes the padding one byte per cycle up to the block
// end, then compresses; when the end marker falls at byte 56 or later a
// second block of zeros and length is written over all 64 bytes and
// compressed too. The digest leaves as two transactions, low half first.
module md5_digest_stream import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [8] has_byte, [15:9] zero
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] digest_half
  output logic        m_tuser,   // half_index
  output logic        m_tlast    // last
);

  dp_ctrl_t    ctrl;
  dp_stat_t    stat;
  logic [5:0]  next_step;
  logic [63:0] half_lo, half_hi;
  logic        in_fire;

  assign in_fire = s_tvalid && s_tready;

  md5_control u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_byte(s_tdata[7:0]),
    .in_has(s_tdata[8]), .in_end(s_tlast), .stat(stat), .out_ready(m_tready),
    .in_rdy(s_tready), .ctrl(ctrl), .next_step(next_step),
    .out_valid(m_tvalid), .out_half(m_tuser)
  );

  md5_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .next_step(next_step), .stat(stat),
    .half_lo(half_lo), .half_hi(half_hi)
  );

  assign m_tdata = m_tuser ? half_hi : half_lo;
  assign m_tlast = m_tuser;

  a_no_intake_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while digest pending");
  a_half_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser) |=> (m_tvalid && m_tuser))
    else $error("high half did not follow low half");
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser) |=> (m_tdata == {IV_B, IV_A}))
    else $error("state not restored after digest");

endmodule

[bench/tb_md5_digest_stream.sv]
// Self-checking testbench for the streaming MD5 digest block.
module tb_md5_digest_stream;
  import md5_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_msg;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] half;
    logic        half_idx;
    logic        last;
  } digest_res_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tlast;
  logic [15:0] s_tdata;
  logic        m_tvalid, m_tready, m_tuser, m_tlast;
  logic [63:0] m_tdata;

  md5_digest_stream dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // predictor state
  logic [31:0] hash_w[4];
  logic [7:0]  blk_buf[64];
  int unsigned blk_fill;
  logic [60:0] msg_len;

  msg_item_t   pending_items[$];
  digest_res_t expected_digests[$];
  int          mismatches;
  int          idle_cycles;
  bit          stim_done;
  bit          drain_hold;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void hash_reset();
    hash_w[0] = 32'h67452301;
    hash_w[1] = 32'hefcdab89;
    hash_w[2] = 32'h98badcfe;
    hash_w[3] = 32'h10325476;
    foreach (blk_buf[i]) blk_buf[i] = 8'h00;
    blk_fill = 0;
    msg_len = '0;
  endfunction

  function automatic logic [31:0] sine_const(int i);
    logic [31:0] kt[64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return kt[i];
  endfunction

  function automatic void compress();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, f, t, k;
    int g, r, sh;
    int unsigned rots[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
    a = hash_w[0]; b = hash_w[1]; c = hash_w[2]; d = hash_w[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
      endcase
      k = sine_const(i);
      t = a + f + k + w[g];
      sh = rots[r*4 + i%4];
      a = d; d = c; c = b;
      b = b + rotl(t, sh);
    end
    hash_w[0] += a; hash_w[1] += b; hash_w[2] += c; hash_w[3] += d;
  endfunction

  // advance the digest model by one accepted transaction
  function automatic void predict_digest(msg_item_t it);
    logic [63:0] bits;
    digest_res_t r;
    if (it.has_byte) begin
      blk_buf[blk_fill] = it.data_byte;
      blk_fill++;
      msg_len++;
      if (blk_fill == 64) begin
        compress();
        blk_fill = 0;
      end
    end
    if (!it.end_msg) return;
    blk_buf[blk_fill] = PAD_BYTE;
    for (int i = blk_fill + 1; i < 64; i++) blk_buf[i] = 8'h00;
    if (blk_fill + 1 > 56) begin
      compress();
      for (int i = 0; i < 56; i++) blk_buf[i] = 8'h00;
    end
    bits = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) blk_buf[56+i] = bits[8*i +: 8];
    compress();
    r.half = {hash_w[1], hash_w[0]}; r.half_idx = 1'b0; r.last = 1'b0;
    expected_digests.push_back(r);
    r.half = {hash_w[3], hash_w[2]}; r.half_idx = 1'b1; r.last = 1'b1;
    expected_digests.push_back(r);
    hash_reset();
  endfunction

  function automatic msg_item_t mk(logic [7:0] b, logic h, logic e);
    msg_item_t it;
    it.data_byte = b; it.has_byte = h; it.end_msg = e;
    return it;
  endfunction

  // a message of n random bytes; the end flag rides on the last byte or on an empty item
  function automatic void push_message(int n, bit empty_end);
    for (int i = 0; i < n; i++)
      pending_items.push_back(mk(8'($urandom), 1'b1, (i == n-1) && !empty_end));
    if (empty_end || n == 0) pending_items.push_back(mk(8'($urandom), 1'b0, 1'b1));
  endfunction

  // stimulus
  initial begin
    int n;
    hash_reset();
    // directed: empty message, extremes, idle items, pad boundaries
    pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
    pending_items.push_back(mk(8'hff, 1'b1, 1'b1));
    pending_items.push_back(mk(8'h00, 1'b0, 1'b0));
    pending_items.push_back(mk(8'h00, 1'b1, 1'b0));
    pending_items.push_back(mk(8'h5a, 1'b0, 1'b0));
    pending_items.push_back(mk(8'ha5, 1'b1, 1'b1));
    push_message(3, 1'b1);
    push_message(55, 1'b0);
    push_message(56, 1'b0);
    push_message(63, 1'b1);
    push_message(64, 1'b0);
    push_message(64, 1'b1);
    push_message(70, 1'b0);
    while (pending_items.size() < 390) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back(mk(8'($urandom), 1'b0, 1'($urandom)));
        1: push_message($urandom_range(50, 70), 1'($urandom));
        default: push_message($urandom_range(0, 20), 1'($urandom_range(0, 3) == 0));
      endcase
    end
    // last message always ends cleanly
    push_message(5, 1'b0);
  end

  // driver
  int gap_left;
  int sent;
  always @(posedge clk) begin
    msg_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
      gap_left <= 0;
      sent <= 0;
      drain_hold <= 1'b0;
      stim_done <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_digest({s_tdata[7:0], s_tdata[8], s_tlast});
        sent <= sent + 1;
      end
      if (sent == 300 && !drain_hold) begin
        drain_hold <= 1'b1;  // hold off until all digests are back
        s_tvalid <= 1'b0;
      end else if (drain_hold && (expected_digests.size() != 0 || s_tvalid)) begin
        s_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        s_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end else begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, it.has_byte, it.data_byte};
        s_tlast <= it.end_msg;
        gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      end
    end
  end

  // monitor and sink
  int stall_left;
  always @(posedge clk) begin
    digest_res_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
      mismatches <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_digests.size() == 0) begin
          if (mismatches < 10) $display("unexpected digest transaction %h", m_tdata);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_digests.pop_front();
          if (m_tdata !== exp_r.half || m_tuser !== exp_r.half_idx || m_tlast !== exp_r.last)
          begin
            if (mismatches < 10)
              $display("digest mismatch: exp %h/%0b/%0b got %h/%0b/%0b", exp_r.half,
                       exp_r.half_idx, exp_r.last, m_tdata, m_tuser, m_tlast);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if (m_tready && m_tvalid) begin
        stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && expected_digests.size() == 0) && idle_cycles < 2000)
      @(posedge clk);
    if (idle_cycles >= 2000) begin
      $display("end of test: mismatches");
    end else begin
      repeat (300) @(posedge clk);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/md5_pkg.sv
sv/md5_datapath.sv
sv/md5_control.sv
sv/md5_digest_stream.sv
bench/tb_md5_digest_stream.sv
